/* hw/rtl/alu8_pkg.sv */
// Shared types and codes for the 8-bit ALU with status flags.
`timescale 1ns / 1ps

package alu8_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_DAA = 3'd2;
  localparam logic [2:0] OP_CMA = 3'd3;
  localparam logic [2:0] OP_STC = 3'd4;
  localparam logic [2:0] OP_CMC = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] first_operand;
    logic [7:0] second_operand;
    logic       use_carry;
    logic       modify_carry;
    logic       carry_in;
    logic       aux_carry_in;
    logic       zero_in;
    logic       sign_in;
    logic       parity_in;
  } in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       carry_out;
    logic       aux_carry_out;
    logic       zero_out;
    logic       sign_out;
    logic       parity_out;
  } out_t;

endpackage

/* hw/rtl/alu8_with_status_flags_unit.sv */
// 8-bit ALU with carry, nibble carry, zero, sign and parity flags, three-stage pipeline.
`timescale 1ns / 1ps

// Usage:
//   in_valid/in_ready/in_data carry one operation item: selector, two
//   operands, carry controls and the current flags. out_valid/out_ready/
//   out_data carry one result item per input item, in order.
//   Each item passes the adder stage, the select and decimal-adjust stage
//   and the flag and output register stage, in that order. Throughput: one
//   item per cycle unless out_ready is held low; every stage has its own
//   valid bit and the stage registers set the rate, not any shared unit.
//   Stall: when out_ready is low the result holds in the output register;
//   the stages behind it keep filling until each one is occupied, after
//   which in_ready drops. Nothing is dropped or repeated.
//   Reset: rst_n low (synchronous) empties all stages; payload registers
//   are not cleared. No state survives between items.
//   Selector codes 6 and 7 pass the first operand and all flags through.
module alu8_with_status_flags_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  alu8_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output alu8_pkg::out_t out_data
);
  import alu8_pkg::*;

  localparam logic [8:0] DaaLoAdj  = 9'h006;
  localparam logic [8:0] DaaHiAdj  = 9'h060;
  localparam logic [4:0] DigitMax5 = 5'd9;
  localparam logic [3:0] DigitMax4 = 4'd9;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] a;
    logic [7:0] ar_res;
    logic       ar_cy;
    logic       ar_ac;
    logic [8:0] daa_acc;
    logic       mod_c;
    logic       cy;
    logic       ac;
    logic       z;
    logic       s;
    logic       p;
  } s1_t;

  typedef struct packed {
    logic [7:0] res;
    logic       cy;
    logic       ac;
    logic       set_zsp;
    logic       z;
    logic       s;
    logic       p;
  } s2_t;

  logic v1_r, v2_r, v3_r;
  logic rdy2, rdy3;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  out_t s3_r, s3_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;

  // Stage 1: adders for add, subtract and the low decimal-adjust step
  logic       c_eff;
  logic [8:0] add9, sub9;
  logic [4:0] add5, sub5;

  always_comb begin
    c_eff = in_data.use_carry & in_data.carry_in;
    add9  = {1'b0, in_data.first_operand} + {1'b0, in_data.second_operand} + {8'd0, c_eff};
    sub9  = {1'b0, in_data.first_operand} - {1'b0, in_data.second_operand} - {8'd0, c_eff};
    add5  = {1'b0, in_data.first_operand[3:0]} + {1'b0, in_data.second_operand[3:0]}
          + {4'd0, c_eff};
    sub5  = {1'b0, in_data.first_operand[3:0]} - {1'b0, in_data.second_operand[3:0]}
          - {4'd0, c_eff};

    s1_nxt.op    = in_data.req_type;
    s1_nxt.a     = in_data.first_operand;
    s1_nxt.mod_c = in_data.modify_carry;
    s1_nxt.cy    = in_data.carry_in;
    s1_nxt.ac    = in_data.aux_carry_in;
    s1_nxt.z     = in_data.zero_in;
    s1_nxt.s     = in_data.sign_in;
    s1_nxt.p     = in_data.parity_in;
    if (in_data.req_type == OP_SUB) begin
      // bit 8 / bit 4 of the wrapped difference is the borrow
      s1_nxt.ar_res = sub9[7:0];
      s1_nxt.ar_cy  = sub9[8];
      s1_nxt.ar_ac  = sub5[4];
    end else begin
      s1_nxt.ar_res = add9[7:0];
      s1_nxt.ar_cy  = add9[8];
      s1_nxt.ar_ac  = add5[4];
    end
    if (in_data.aux_carry_in || (in_data.first_operand[3:0] > DigitMax4)) begin
      s1_nxt.daa_acc = {1'b0, in_data.first_operand} + DaaLoAdj;
    end else begin
      s1_nxt.daa_acc = {1'b0, in_data.first_operand};
    end
  end

  // Stage 2: operation select, high decimal-adjust step, carry update
  logic [8:0] daa_hi;

  always_comb begin
    daa_hi         = s1_r.daa_acc + DaaHiAdj;
    s2_nxt.res     = s1_r.a;
    s2_nxt.cy      = s1_r.cy;
    s2_nxt.ac      = s1_r.ac;
    s2_nxt.set_zsp = 1'b0;
    s2_nxt.z       = s1_r.z;
    s2_nxt.s       = s1_r.s;
    s2_nxt.p       = s1_r.p;
    case (s1_r.op)
      OP_ADD, OP_SUB: begin
        s2_nxt.res     = s1_r.ar_res;
        s2_nxt.ac      = s1_r.ar_ac;
        s2_nxt.cy      = s1_r.mod_c ? s1_r.ar_cy : s1_r.cy;
        s2_nxt.set_zsp = 1'b1;
      end
      OP_DAA: begin
        // high part is taken unwrapped, so a carry out of bit 7 counts as > 9
        if (s1_r.cy || (s1_r.daa_acc[8:4] > DigitMax5)) begin
          s2_nxt.res = daa_hi[7:0];
          s2_nxt.cy  = 1'b1;
        end else begin
          s2_nxt.res = s1_r.daa_acc[7:0];
        end
        s2_nxt.set_zsp = 1'b1;
      end
      OP_CMA: s2_nxt.res = ~s1_r.a;
      OP_STC: s2_nxt.cy = 1'b1;
      OP_CMC: s2_nxt.cy = ~s1_r.cy;
      default: ;
    endcase
  end

  // Stage 3: zero, sign, parity
  always_comb begin
    s3_nxt.result        = s2_r.res;
    s3_nxt.carry_out     = s2_r.cy;
    s3_nxt.aux_carry_out = s2_r.ac;
    if (s2_r.set_zsp) begin
      s3_nxt.zero_out   = (s2_r.res == 8'd0);
      s3_nxt.sign_out   = s2_r.res[7];
      s3_nxt.parity_out = ~^s2_r.res;
    end else begin
      s3_nxt.zero_out   = s2_r.z;
      s3_nxt.sign_out   = s2_r.s;
      s3_nxt.parity_out = s2_r.p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_r <= s1_nxt;
    if (v1_r && rdy2)         s2_r <= s2_nxt;
    if (v2_r && rdy3)         s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

/* hw/rtl/alu8_chk.sv */
// Port-level checker for the ALU pipeline, bound to the top level.
`timescale 1ns / 1ps

module alu8_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input alu8_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input alu8_pkg::out_t out_data
);
  import alu8_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed or vanished while stalled");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up when every stage is full and the output is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output side could move");

  // output valid only drops after the item was taken
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result item dropped without handshake");

endmodule

bind alu8_with_status_flags_unit alu8_chk u_alu8_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/tb_alu8_with_status_flags_unit.sv */
// Self-checking testbench for the 8-bit ALU with status flags: directed table, then random items.
`timescale 1ns / 1ps

module tb_alu8_with_status_flags_unit;
  import alu8_pkg::*;

  // selector codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
  localparam logic [8:0] BCD_LOW_FIX   = 9'h006;
  localparam logic [8:0] BCD_HIGH_FIX  = 9'h060;

  localparam int RANDOM_ITEMS_PER_PHASE = 640;
  localparam int HOLD_OFF_CYCLES        = 50;
  localparam int STALL_LIMIT            = 2000;
  localparam int DRAIN_CYCLES           = 8;
  localparam int MAX_PRINTED            = 60;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t     flags_q[$];
  dir_row_t dir_rows[$];

  // expectation that travels with the item currently offered
  bit   cur_typed;
  out_t cur_want;

  int error_count  = 0;
  int stall_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_pending;
  bit hold_done;
  int hold_left;

  alu8_with_status_flags_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic out_t alu_flags_predict(in_t it);
    out_t       r;
    logic       cin;
    logic [8:0] wide;
    logic [4:0] nib;
    logic       set_zsp;
    r.result        = it.first_operand;
    r.carry_out     = it.carry_in;
    r.aux_carry_out = it.aux_carry_in;
    r.zero_out      = it.zero_in;
    r.sign_out      = it.sign_in;
    r.parity_out    = it.parity_in;
    cin     = it.use_carry & it.carry_in;
    set_zsp = 1'b0;
    case (it.req_type)
      OP_ADD: begin
        wide = {1'b0, it.first_operand} + {1'b0, it.second_operand} + 9'(cin);
        nib  = {1'b0, it.first_operand[3:0]} + {1'b0, it.second_operand[3:0]} + 5'(cin);
        r.result        = wide[7:0];
        r.aux_carry_out = nib[4];
        if (it.modify_carry) r.carry_out = wide[8];
        set_zsp = 1'b1;
      end
      OP_SUB: begin
        // bit 8 / bit 4 of the wrapped difference is the borrow
        wide = {1'b0, it.first_operand} - {1'b0, it.second_operand} - 9'(cin);
        nib  = {1'b0, it.first_operand[3:0]} - {1'b0, it.second_operand[3:0]} - 5'(cin);
        r.result        = wide[7:0];
        r.aux_carry_out = nib[4];
        if (it.modify_carry) r.carry_out = wide[8];
        set_zsp = 1'b1;
      end
      OP_DAA: begin
        wide = {1'b0, it.first_operand};
        if (it.aux_carry_in || wide[3:0] > BCD_MAX_DIGIT) wide = wide + BCD_LOW_FIX;
        // high part includes bit 8, so a carry out of bit 7 counts as > 9
        if (it.carry_in || wide[8:4] > 5'(BCD_MAX_DIGIT)) begin
          wide        = wide + BCD_HIGH_FIX;
          r.carry_out = 1'b1;
        end
        r.result = wide[7:0];
        set_zsp  = 1'b1;
      end
      OP_CMA: r.result = ~it.first_operand;
      OP_STC: r.carry_out = 1'b1;
      OP_CMC: r.carry_out = ~it.carry_in;
      default: ;
    endcase
    if (set_zsp) begin
      r.zero_out   = (r.result == 8'h00);
      r.sign_out   = r.result[7];
      r.parity_out = ~^r.result;
    end
    return r;
  endfunction

  function automatic in_t make_op(logic [2:0] op, logic [7:0] a, logic [7:0] b,
                                  logic uc, logic mc, logic [4:0] flags);
    in_t it;
    it.req_type       = op;
    it.first_operand  = a;
    it.second_operand = b;
    it.use_carry      = uc;
    it.modify_carry   = mc;
    {it.carry_in, it.aux_carry_in, it.zero_in, it.sign_in, it.parity_in} = flags;
    return it;
  endfunction

  function automatic out_t make_flags(logic [7:0] res, logic [4:0] flags);
    out_t r;
    r.result = res;
    {r.carry_out, r.aux_carry_out, r.zero_out, r.sign_out, r.parity_out} = flags;
    return r;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[8];
    corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h99, 8'h9A, 8'h80, 8'h7F};
    if ($urandom_range(7) == 0) return corners[3'($urandom_range(7))];
    return 8'($urandom);
  endfunction

  function automatic in_t random_op();
    in_t        it;
    logic [2:0] op;
    int         r;
    r = $urandom_range(99);
    if (r < 4)      op = OP_SPARE6;
    else if (r < 8) op = OP_SPARE7;
    else            op = 3'($urandom_range(5));
    it = make_op(op, pick_operand(), pick_operand(), 1'($urandom), 1'($urandom),
                 5'($urandom));
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < MAX_PRINTED)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // offers one item at the falling edge, returns at the falling edge after acceptance
  task automatic send_item(in_t it, bit typed, out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data   = it;
    cur_typed = typed;
    cur_want  = want;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (flags_q.size() != 0) @(negedge clk);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_pending && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // scoreboard and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (flags_q.size() == 0) begin
          report_mismatch("unexpected item", 32'(out_data), 32'(0));
        end else begin
          out_t want;
          want = flags_q.pop_front();
          if (out_data.result !== want.result)
            report_mismatch("result", 32'(out_data.result), 32'(want.result));
          if (out_data.carry_out !== want.carry_out)
            report_mismatch("carry_out", 32'(out_data.carry_out), 32'(want.carry_out));
          if (out_data.aux_carry_out !== want.aux_carry_out)
            report_mismatch("aux_carry_out", 32'(out_data.aux_carry_out),
                            32'(want.aux_carry_out));
          if (out_data.zero_out !== want.zero_out)
            report_mismatch("zero_out", 32'(out_data.zero_out), 32'(want.zero_out));
          if (out_data.sign_out !== want.sign_out)
            report_mismatch("sign_out", 32'(out_data.sign_out), 32'(want.sign_out));
          if (out_data.parity_out !== want.parity_out)
            report_mismatch("parity_out", 32'(out_data.parity_out), 32'(want.parity_out));
        end
      end
      if (in_valid && in_ready)
        flags_q.push_back(cur_typed ? cur_want : alu_flags_predict(in_data));
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    // flag vectors are {carry, aux carry, zero, sign, parity}
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cur_typed     = 1'b0;
    cur_want      = '0;
    hold_pending  = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 61;

    dir_rows.push_back('{make_op(OP_ADD, 8'h00, 8'h00, 1'b0, 1'b1, 5'b00000), 1'b1,
                         make_flags(8'h00, 5'b00101)});
    dir_rows.push_back('{make_op(OP_ADD, 8'hFF, 8'h01, 1'b0, 1'b1, 5'b00000), 1'b1,
                         make_flags(8'h00, 5'b11101)});
    dir_rows.push_back('{make_op(OP_ADD, 8'hFF, 8'hFF, 1'b1, 1'b1, 5'b10000), 1'b1,
                         make_flags(8'hFF, 5'b11011)});
    // carry left alone without modify_carry
    dir_rows.push_back('{make_op(OP_ADD, 8'h0F, 8'h01, 1'b0, 1'b0, 5'b10000), 1'b1,
                         make_flags(8'h10, 5'b11000)});
    dir_rows.push_back('{make_op(OP_ADD, 8'h7F, 8'h00, 1'b1, 1'b1, 5'b01111), 1'b1,
                         make_flags(8'h7F, 5'b00000)});
    dir_rows.push_back('{make_op(OP_ADD, 8'h08, 8'h08, 1'b1, 1'b1, 5'b10000), 1'b0, '0});
    dir_rows.push_back('{make_op(OP_SUB, 8'h00, 8'h01, 1'b0, 1'b1, 5'b00000), 1'b1,
                         make_flags(8'hFF, 5'b11011)});
    dir_rows.push_back('{make_op(OP_SUB, 8'h00, 8'hFF, 1'b1, 1'b1, 5'b10000), 1'b1,
                         make_flags(8'h00, 5'b11101)});
    dir_rows.push_back('{make_op(OP_SUB, 8'h55, 8'h55, 1'b0, 1'b1, 5'b11010), 1'b1,
                         make_flags(8'h00, 5'b00101)});
    dir_rows.push_back('{make_op(OP_SUB, 8'h10, 8'h01, 1'b0, 1'b0, 5'b00000), 1'b1,
                         make_flags(8'h0F, 5'b01001)});
    dir_rows.push_back('{make_op(OP_SUB, 8'h80, 8'h7F, 1'b1, 1'b1, 5'b10111), 1'b0, '0});
    dir_rows.push_back('{make_op(OP_DAA, 8'h9A, 8'h00, 1'b0, 1'b0, 5'b00000), 1'b1,
                         make_flags(8'h00, 5'b10101)});
    // low fix carries out of bit 7, which forces the high fix too
    dir_rows.push_back('{make_op(OP_DAA, 8'hFA, 8'h00, 1'b0, 1'b0, 5'b00000), 1'b0, '0});
    dir_rows.push_back('{make_op(OP_DAA, 8'h99, 8'h00, 1'b0, 1'b0, 5'b00000), 1'b1,
                         make_flags(8'h99, 5'b00011)});
    dir_rows.push_back('{make_op(OP_DAA, 8'h00, 8'h00, 1'b0, 1'b0, 5'b11000), 1'b1,
                         make_flags(8'h66, 5'b11001)});
    dir_rows.push_back('{make_op(OP_DAA, 8'h15, 8'h3C, 1'b1, 1'b1, 5'b00111), 1'b0, '0});
    dir_rows.push_back('{make_op(OP_CMA, 8'h00, 8'h12, 1'b1, 1'b1, 5'b11110), 1'b1,
                         make_flags(8'hFF, 5'b11110)});
    // zero flag is not touched even though the result is zero
    dir_rows.push_back('{make_op(OP_CMA, 8'hFF, 8'h00, 1'b0, 1'b0, 5'b00000), 1'b1,
                         make_flags(8'h00, 5'b00000)});
    dir_rows.push_back('{make_op(OP_STC, 8'hA5, 8'hFF, 1'b0, 1'b0, 5'b01010), 1'b1,
                         make_flags(8'hA5, 5'b11010)});
    dir_rows.push_back('{make_op(OP_CMC, 8'h3C, 8'h00, 1'b1, 1'b1, 5'b10101), 1'b1,
                         make_flags(8'h3C, 5'b00101)});
    dir_rows.push_back('{make_op(OP_CMC, 8'h3C, 8'h00, 1'b0, 1'b0, 5'b01010), 1'b1,
                         make_flags(8'h3C, 5'b11010)});
    dir_rows.push_back('{make_op(OP_SPARE6, 8'h81, 8'hFF, 1'b1, 1'b1, 5'b10101), 1'b1,
                         make_flags(8'h81, 5'b10101)});
    dir_rows.push_back('{make_op(OP_SPARE7, 8'h7E, 8'h00, 1'b1, 1'b1, 5'b01010), 1'b1,
                         make_flags(8'h7E, 5'b01010)});

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    in_valid = 1'b0;
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 61;
          hold_pending  = 1'b1;   // receiver stalls long while items keep coming
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) send_item(random_op(), 1'b0, '0);
      in_valid = 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
